// ===== design/enba_pkg.sv =====
// shared types, codes and defaults for the event number bitmap allocator
// depends on nothing; used by the controller, the datapath and the top level
`default_nettype none

package enba_pkg;

  // default pool sizes
  localparam int DEF_TOTAL_EVENTS     = 256;
  localparam int DEF_HIGH_PRIO_EVENTS = 32;

  // bitmap bits examined per scan cycle
  localparam int SCAN_W = 32;

  // field widths
  localparam int KIND_W  = 2;
  localparam int EVENT_W = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC_NORMAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC_HIGH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE         = 2'd2;

  // result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_RES = 1'b1;

  // input transfer payload
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [EVENT_W-1:0] event_number;
  } req_t;

  // result transfer payload
  typedef struct packed {
    logic [EVENT_W-1:0] granted_event;
    logic               status;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic scan;    // examine the current bitmap word
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hit;   // free number found in the current word
    logic last;  // current word is the last one of the pool
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/enba_ctrl.sv =====
// controller state machine of the event number bitmap allocator
// depends on enba_pkg; drives the datapath through dp_cmd_t, reads dp_sts_t
`default_nettype none

module enba_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [enba_pkg::KIND_W-1:0] kind,
  input  wire enba_pkg::dp_sts_t          sts,
  output enba_pkg::dp_cmd_t               cmd,
  output logic                            busy,
  output logic                            done
);

  enba_pkg::state_t state, state_next;
  logic             accept;
  logic             is_alloc;

  assign accept   = start && (state == enba_pkg::ST_IDLE);
  assign is_alloc = (kind == enba_pkg::KIND_ALLOC_NORMAL) ||
                    (kind == enba_pkg::KIND_ALLOC_HIGH);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= enba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      enba_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = is_alloc ? enba_pkg::ST_SCAN : enba_pkg::ST_RESP;
        end
      end
      enba_pkg::ST_SCAN: begin
        if (sts.hit || sts.last) begin
          state_next = enba_pkg::ST_RESP;
        end
      end
      enba_pkg::ST_RESP: begin
        state_next = enba_pkg::ST_IDLE;
      end
      default: begin
        state_next = enba_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.accept = accept;
    cmd.scan   = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      enba_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      enba_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      enba_pkg::ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // an accepted request always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // busy only drops right after a result transfer
  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result transfer");

  // a scan ends in exactly one result strobe
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && (sts.hit || sts.last)) |=> (done ##1 !done))
    else $error("finished scan did not give a single result strobe");

endmodule

`default_nettype wire

// ===== design/enba_datapath.sv =====
// bitmap datapath: allocation bits, word scan with first-free search, result register
// depends on enba_pkg; controlled by enba_ctrl
`default_nettype none

module enba_datapath #(
  parameter int TOTAL_EVENTS     = enba_pkg::DEF_TOTAL_EVENTS,
  parameter int HIGH_PRIO_EVENTS = enba_pkg::DEF_HIGH_PRIO_EVENTS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire enba_pkg::dp_cmd_t  cmd,
  input  wire enba_pkg::req_t     request,
  output enba_pkg::dp_sts_t       sts,
  output enba_pkg::rsp_t          result
);

  localparam int NORMAL_END = (HIGH_PRIO_EVENTS >= TOTAL_EVENTS) ? 0 :
                              TOTAL_EVENTS - HIGH_PRIO_EVENTS;
  localparam int NUM_WORDS  = (TOTAL_EVENTS + enba_pkg::SCAN_W - 1) / enba_pkg::SCAN_W;
  localparam int WORD_IW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W      = $clog2(enba_pkg::SCAN_W);
  localparam int SPAN_W     = WORD_IW + BIT_W + 1;
  localparam int CMP_W      = $clog2(TOTAL_EVENTS + 1) + enba_pkg::EVENT_W;

  // pool word ranges
  localparam int N_FIRST_W = 0;
  localparam int N_LAST_W  = (NORMAL_END == 0) ? 0 : (NORMAL_END - 1) / enba_pkg::SCAN_W;
  localparam int H_FIRST_W = NORMAL_END / enba_pkg::SCAN_W;
  localparam int H_LAST_W  = (TOTAL_EVENTS - 1) / enba_pkg::SCAN_W;

  localparam logic [SPAN_W-1:0] N_LO = SPAN_W'(0);
  localparam logic [SPAN_W-1:0] N_HI = SPAN_W'(NORMAL_END);
  localparam logic [SPAN_W-1:0] H_LO = SPAN_W'(NORMAL_END);
  localparam logic [SPAN_W-1:0] H_HI = SPAN_W'(TOTAL_EVENTS);

  logic [enba_pkg::SCAN_W-1:0] bitmap [NUM_WORDS];
  logic [WORD_IW-1:0]          scan_word;
  logic                        pool_high;
  enba_pkg::rsp_t              rsp;

  logic [enba_pkg::SCAN_W-1:0] word_bits;
  logic [enba_pkg::SCAN_W-1:0] in_pool;
  logic [enba_pkg::SCAN_W-1:0] cand;
  logic [BIT_W-1:0]            hit_bit;
  logic                        hit;
  logic [WORD_IW-1:0]          last_word;
  logic [SPAN_W-1:0]           lo;
  logic [SPAN_W-1:0]           hi;
  logic [SPAN_W-1:0]           hit_idx;
  logic                        is_alloc;
  logic                        free_ok;
  logic [WORD_IW-1:0]          free_word;
  logic [BIT_W-1:0]            free_bit;

  // pool bounds of the request in progress
  assign lo        = pool_high ? H_LO : N_LO;
  assign hi        = pool_high ? H_HI : N_HI;
  assign last_word = pool_high ? WORD_IW'(H_LAST_W) : WORD_IW'(N_LAST_W);

  // candidate free bits of the current word inside the pool
  assign word_bits = bitmap[scan_word];
  always_comb begin
    logic [SPAN_W-1:0] idx;
    for (int j = 0; j < enba_pkg::SCAN_W; j++) begin
      idx        = SPAN_W'({scan_word, BIT_W'(j)});
      in_pool[j] = (idx >= lo) && (idx < hi);
    end
  end
  assign cand = ~word_bits & in_pool;

  // lowest candidate bit
  always_comb begin
    hit_bit = '0;
    for (int j = enba_pkg::SCAN_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_bit = BIT_W'(j);
      end
    end
  end
  assign hit     = |cand;
  assign hit_idx = SPAN_W'({scan_word, hit_bit});

  assign sts.hit  = hit;
  assign sts.last = (scan_word == last_word);

  // request decode
  assign is_alloc  = (request.kind == enba_pkg::KIND_ALLOC_NORMAL) ||
                     (request.kind == enba_pkg::KIND_ALLOC_HIGH);
  assign free_ok   = (request.kind == enba_pkg::KIND_FREE) &&
                     (CMP_W'(request.event_number) < CMP_W'(TOTAL_EVENTS));
  assign free_word = WORD_IW'(request.event_number >> BIT_W);
  assign free_bit  = request.event_number[BIT_W-1:0];

  // allocation bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        bitmap[w] <= '0;
      end
    end else if (cmd.accept && free_ok) begin
      bitmap[free_word][free_bit] <= 1'b0;
    end else if (cmd.scan && hit) begin
      bitmap[scan_word][hit_bit] <= 1'b1;
    end
  end

  // scan position and pool select
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_word <= '0;
      pool_high <= 1'b0;
    end else if (cmd.accept && is_alloc) begin
      pool_high <= (request.kind == enba_pkg::KIND_ALLOC_HIGH);
      scan_word <= (request.kind == enba_pkg::KIND_ALLOC_HIGH) ?
                   WORD_IW'(H_FIRST_W) : WORD_IW'(N_FIRST_W);
    end else if (cmd.scan && !hit && !sts.last) begin
      scan_word <= scan_word + WORD_IW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rsp.granted_event <= '0;
      rsp.status        <= enba_pkg::STATUS_OK;
    end else if (cmd.scan && hit) begin
      rsp.granted_event <= enba_pkg::EVENT_W'(hit_idx);
      rsp.status        <= enba_pkg::STATUS_OK;
    end else if (cmd.scan && sts.last) begin
      rsp.granted_event <= '0;
      rsp.status        <= enba_pkg::STATUS_NO_RES;
    end
  end

  assign result = rsp;

endmodule

`default_nettype wire

// ===== design/event_number_bitmap_allocator_top.sv =====
// top level of the event number bitmap allocator
// depends on enba_pkg, enba_ctrl and enba_datapath
//
//   channel   signals                 direction  transfer when
//   request   start, busy, request    in         start high and busy low at a clock edge
//   result    done, result            out        every cycle with done high
//
// a free request (or an unused kind) gives its result in the cycle after the transfer;
// an allocation scans the pool one 32-bit bitmap word per cycle, from the first word of
// the pool until a word holds a free number or the last word of the pool is reached,
// and then gives its result from the result state. busy stays high through the result
// cycle, so a new request can follow the cycle after done. rst clears the whole bitmap.
// the receiver cannot stall; done lasts exactly one cycle.
`default_nettype none

module event_number_bitmap_allocator_top #(
  parameter int TOTAL_EVENTS     = enba_pkg::DEF_TOTAL_EVENTS,
  parameter int HIGH_PRIO_EVENTS = enba_pkg::DEF_HIGH_PRIO_EVENTS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire enba_pkg::req_t  request,
  output logic                 busy,
  output logic                 done,
  output enba_pkg::rsp_t       result
);

  enba_pkg::dp_cmd_t cmd;
  enba_pkg::dp_sts_t sts;

  // sequencing
  enba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // bitmap and search
  enba_datapath #(
    .TOTAL_EVENTS     (TOTAL_EVENTS),
    .HIGH_PRIO_EVENTS (HIGH_PRIO_EVENTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .sts     (sts),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== tb/event_number_bitmap_allocator_top_tb.sv =====
// testbench for event_number_bitmap_allocator_top: directed table, then random request episodes
// depends on enba_pkg and the top level; results are checked against the table or a shadow bitmap
`timescale 1ns / 100ps

module event_number_bitmap_allocator_top_tb;
  import enba_pkg::*;

  localparam int TOTAL_EVENTS     = DEF_TOTAL_EVENTS;
  localparam int HIGH_PRIO_EVENTS = DEF_HIGH_PRIO_EVENTS;
  localparam int NORMAL_END       = (HIGH_PRIO_EVENTS >= TOTAL_EVENTS) ? 0 :
                                    TOTAL_EVENTS - HIGH_PRIO_EVENTS;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1180;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  bit   shadow_map [TOTAL_EVENTS];
  rsp_t awaited_grants [$];
  int   n_sent = 0;
  int   n_fail = 0;
  int   tail_start = 0;
  bit   quiet = 1'b0;

  event_number_bitmap_allocator_top #(
    .TOTAL_EVENTS    (TOTAL_EVENTS),
    .HIGH_PRIO_EVENTS(HIGH_PRIO_EVENTS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // predicted grant for one request, updates the shadow bitmap
  function automatic rsp_t next_grant(input req_t r);
    rsp_t o;
    int   lo;
    int   hi;
    int   i;
    bit   found;
    o.granted_event = '0;
    o.status = STATUS_OK;
    found = 1'b0;
    if (r.kind == KIND_ALLOC_NORMAL || r.kind == KIND_ALLOC_HIGH) begin
      lo = (r.kind == KIND_ALLOC_NORMAL) ? 0 : NORMAL_END;
      hi = (r.kind == KIND_ALLOC_NORMAL) ? NORMAL_END : TOTAL_EVENTS;
      for (i = lo; i < hi && !found; i++) begin
        if (!shadow_map[i]) begin
          shadow_map[i] = 1'b1;
          o.granted_event = 8'(i);
          found = 1'b1;
        end
      end
      if (!found) o.status = STATUS_NO_RES;
    end else if (r.kind == KIND_FREE) begin
      if (int'(r.event_number) < TOTAL_EVENTS) shadow_map[r.event_number] = 1'b0;
    end
    return o;
  endfunction

  // free numbers left in the pool that an allocation kind draws from
  function automatic int free_in_pool(input logic [KIND_W-1:0] kind);
    int lo;
    int hi;
    int i;
    int n;
    lo = (kind == KIND_ALLOC_NORMAL) ? 0 : NORMAL_END;
    hi = (kind == KIND_ALLOC_NORMAL) ? NORMAL_END : TOTAL_EVENTS;
    n = 0;
    for (i = lo; i < hi; i++) if (!shadow_map[i]) n++;
    return n;
  endfunction

  function automatic int count_used();
    int i;
    int n;
    n = 0;
    for (i = 0; i < TOTAL_EVENTS; i++) if (shadow_map[i]) n++;
    return n;
  endfunction

  // a random number that is currently allocated, or any number if none is
  function automatic logic [EVENT_W-1:0] pick_used_number();
    int used [$];
    int i;
    for (i = 0; i < TOTAL_EVENTS; i++) if (shadow_map[i]) used.push_back(i);
    if (used.size() == 0) return 8'($urandom_range(0, 255));
    return 8'(used[$urandom_range(0, used.size() - 1)]);
  endfunction

  // mixed traffic: allocations, frees of live and random numbers, unused kind
  function automatic req_t churn_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 19);
    r.event_number = 8'($urandom_range(0, 255));
    if (pick <= 7) r.kind = KIND_ALLOC_NORMAL;
    else if (pick <= 10) r.kind = KIND_ALLOC_HIGH;
    else if (pick <= 18) r.kind = KIND_FREE;
    else r.kind = KIND_UNUSED;
    if (pick >= 11 && pick <= 17) r.event_number = pick_used_number();
    return r;
  endfunction

  function automatic step_t row(input logic [KIND_W-1:0] kind, input logic [EVENT_W-1:0] num,
                                input logic typed, input logic [EVENT_W-1:0] grant,
                                input logic status);
    step_t s;
    s.req.kind = kind;
    s.req.event_number = num;
    s.typed = typed;
    s.want.granted_event = grant;
    s.want.status = status;
    return s;
  endfunction

  // drive one request and hold it until the transfer happens
  task automatic send_request(input req_t r, input logic typed, input rsp_t want);
    rsp_t predicted;
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_grant(r);
    awaited_grants.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  // random idle burst on the request side
  task automatic sender_gap();
    if (n_sent < tail_start && !quiet && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // stop sending until every expected result has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (awaited_grants.size() != 0);
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (awaited_grants.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result, expected none, actual grant %0d status %0d",
                 $time, result.granted_event, result.status);
      end else begin
        want = awaited_grants.pop_front();
        if (result.granted_event !== want.granted_event || result.status !== want.status) begin
          n_fail++;
          $display("%0t: mismatch, expected grant %0d status %0d, actual grant %0d status %0d",
                   $time, want.granted_event, want.status,
                   result.granted_event, result.status);
        end
      end
    end
  end

  // stimulus
  initial begin
    step_t plan [$];
    req_t  r;
    rsp_t  none;
    int    k;
    int    n_ep;
    int    ep;
    int    count;
    logic [KIND_W-1:0] fill_kind;

    none = '0;
    for (k = 0; k < TOTAL_EVENTS; k++) shadow_map[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table: reset state, pool edges, double free, unused kind
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd0,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd255, 1'b1, 8'd1,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_HIGH,   8'd0,   1'b1, 8'd224, STATUS_OK));
    plan.push_back(row(KIND_ALLOC_HIGH,   8'd170, 1'b1, 8'd225, STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd0,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd85,  1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd1,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd1,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd0,   1'b1, 8'd1,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd255, 1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd224, 1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_HIGH,   8'd255, 1'b1, 8'd224, STATUS_OK));
    plan.push_back(row(KIND_UNUSED,       8'd0,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_UNUSED,       8'd255, 1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd15,  1'b0, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd223, 1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd2,   1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_NORMAL, 8'd240, 1'b0, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_FREE,         8'd225, 1'b1, 8'd0,   STATUS_OK));
    plan.push_back(row(KIND_ALLOC_HIGH,   8'd0,   1'b0, 8'd0,   STATUS_OK));

    tail_start = plan.size() + RANDOM_ITEMS - 150;
    for (k = 0; k < plan.size(); k++) begin
      sender_gap();
      send_request(plan[k].req, plan[k].typed, plan[k].want);
    end
    hold_until_drained();

    // random episodes; the first two fill the high and then the normal pool past full
    n_ep = 0;
    while (n_sent < plan.size() + RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (n_ep > 1 && n_sent < tail_start && $urandom_range(0, 7) == 0) hold_until_drained();
      ep = (n_ep < 2) ? 0 : $urandom_range(0, 9);
      if (ep <= 1) begin
        // fill one pool and run a few requests into the full pool
        if (n_ep == 0) fill_kind = KIND_ALLOC_HIGH;
        else if (n_ep == 1) fill_kind = KIND_ALLOC_NORMAL;
        else fill_kind = $urandom_range(0, 1) ? KIND_ALLOC_HIGH : KIND_ALLOC_NORMAL;
        count = free_in_pool(fill_kind) + $urandom_range(1, 4);
        repeat (count) begin
          r.kind = fill_kind;
          r.event_number = 8'($urandom_range(0, 255));
          sender_gap();
          send_request(r, 1'b0, none);
        end
      end else if (ep <= 3) begin
        // release a random share of the live numbers
        count = count_used();
        count = $urandom_range(1, (count > 0) ? count : 1);
        repeat (count) begin
          r.kind = KIND_FREE;
          r.event_number = pick_used_number();
          sender_gap();
          send_request(r, 1'b0, none);
        end
      end else begin
        repeat ($urandom_range(10, 40)) begin
          r = churn_request();
          sender_gap();
          send_request(r, 1'b0, none);
        end
      end
      n_ep++;
    end

    // wait for the last results, then let the block settle
    start <= 1'b0;
    do @(posedge clk); while (awaited_grants.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
